// ----- sv/periodic_oneshot_timer_bank_assert.svh -----
`ifndef PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH
`define PERIODIC_ONESHOT_TIMER_BANK_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during reset
`define POTB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer bank check failed");

// next-cycle implication, checked on clk, quiet during reset
`define POTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer bank check failed");

`endif

// ----- sv/potb_pkg.sv -----
package potb_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int RESULT_CAP     = 16;
	localparam int RES_W          = 5;

	localparam int OP_W     = 2;
	localparam int PERIOD_W = 16;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 4;
	localparam int LIVE_W   = 5;

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
	localparam logic [OP_W-1:0] OP_POLL   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DUE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK,
		ST_CREATE,
		ST_POLL,
		ST_EMPTY
	} state_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_CREATE,
		EM_FULL,
		EM_DUE,
		EM_EMPTY
	} emit_t;

	typedef struct packed {
		logic  load;
		logic  start;
		logic  adv;
		logic  tick_upd;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic s0_end;
		logic s0_free;
		logic s1_vld;
		logic s1_hit;
		logic s1_last;
		logic out_free;
	} sts_t;

endpackage

// ----- sv/potb_ctrl.sv -----
module potb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [potb_pkg::OP_W-1:0]   operation,
	input  potb_pkg::sts_t              sts,
	output potb_pkg::cmd_t              cmd
);

	potb_pkg::state_t state_q, state_nx;
	logic accept;

	assign in_stall = (state_q != potb_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= potb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx     = state_q;
		cmd.load     = 1'b0;
		cmd.start    = 1'b0;
		cmd.adv      = 1'b0;
		cmd.tick_upd = 1'b0;
		cmd.emit     = potb_pkg::EM_NONE;
		unique case (state_q)
			potb_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					cmd.start = 1'b1;
					unique case (operation)
						potb_pkg::OP_TICK:   state_nx = potb_pkg::ST_TICK;
						potb_pkg::OP_CREATE: state_nx = potb_pkg::ST_CREATE;
						potb_pkg::OP_POLL:   state_nx = potb_pkg::ST_POLL;
						default:             state_nx = potb_pkg::ST_IDLE;
					endcase
				end
			end
			potb_pkg::ST_TICK: begin
				cmd.adv      = 1'b1;
				cmd.tick_upd = sts.s1_vld;
				if (sts.s0_end) begin
					state_nx = potb_pkg::ST_IDLE;
				end
			end
			potb_pkg::ST_CREATE: begin
				if (sts.s0_end) begin
					if (sts.out_free) begin
						cmd.emit = potb_pkg::EM_FULL;
						state_nx = potb_pkg::ST_IDLE;
					end
				end else if (sts.s0_free) begin
					if (sts.out_free) begin
						cmd.emit = potb_pkg::EM_CREATE;
						state_nx = potb_pkg::ST_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			potb_pkg::ST_POLL: begin
				if (sts.s1_vld && sts.s1_hit) begin
					if (sts.out_free) begin
						cmd.emit = potb_pkg::EM_DUE;
						cmd.adv  = 1'b1;
						if (sts.s1_last) begin
							state_nx = potb_pkg::ST_IDLE;
						end
					end
				end else if (sts.s0_end && !sts.s1_vld) begin
					state_nx = potb_pkg::ST_EMPTY;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			potb_pkg::ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit = potb_pkg::EM_EMPTY;
					state_nx = potb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = potb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/potb_dpath.sv -----
module potb_dpath #(
	parameter int SLOTS      = potb_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = potb_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [potb_pkg::PERIOD_W-1:0]   period,
	input  logic                            one_shot,
	input  potb_pkg::cmd_t                  cmd,
	output potb_pkg::sts_t                  sts,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [potb_pkg::KIND_W-1:0]     kind,
	output logic [potb_pkg::SLOT_W-1:0]     slot,
	output logic                            was_one_shot,
	output logic                            full_error,
	output logic [potb_pkg::LIVE_W-1:0]     live_count,
	output logic                            last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int PW = potb_pkg::PERIOD_W;
	localparam int EW = (COUNT_BITS > PW) ? COUNT_BITS : PW;
	localparam int RW = potb_pkg::RES_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// input item
	logic [PW-1:0] period_q;
	logic          single_q;

	// slot walk
	logic [IW:0]   idx_q;
	logic [IW-1:0] idx0;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [PW:0]   per_s1;
	logic [COUNT_BITS-1:0] cnt_s1;

	// slot table
	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] due_q;
	logic [LW-1:0]    live_q;
	logic [RW-1:0]    res_q;
	logic [PW:0]           per_mem [SLOTS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOTS];

	// output register
	logic                        out_valid_q;
	logic [potb_pkg::KIND_W-1:0] kind_q;
	logic [potb_pkg::SLOT_W-1:0] slot_q;
	logic                        was_q;
	logic                        full_q;
	logic [potb_pkg::LIVE_W-1:0] live_out_q;
	logic                        last_q;

	logic                  s0_end;
	logic                  step0;
	logic                  create_act;
	logic                  serve;
	logic                  tick_act;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  fire;
	logic                  cnt_we;
	logic [IW-1:0]         cnt_addr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [SLOTS-1:0]      above;
	logic                  more;
	logic                  out_free;

	assign idx0       = idx_q[IW-1:0];
	assign s0_end     = (idx_q == (IW+1)'(SLOTS));
	assign step0      = cmd.adv && !s0_end;
	assign create_act = (cmd.emit == potb_pkg::EM_CREATE);
	assign serve      = (cmd.emit == potb_pkg::EM_DUE);
	assign out_free   = !out_valid_q || !out_stall;

	// saturating count step of one slot
	assign cnt_inc  = (cnt_s1 == CNT_MAX) ? cnt_s1 : cnt_s1 + 1'b1;
	assign fire     = (EW'(cnt_inc) >= EW'(per_s1[PW-1:0])) || (cnt_inc == CNT_MAX);
	assign tick_act = cmd.tick_upd && used_q[idx_s1] && !due_q[idx_s1];

	assign cnt_we    = create_act || tick_act;
	assign cnt_addr  = create_act ? idx0 : idx_s1;
	assign cnt_wdata = (create_act || fire) ? '0 : cnt_inc;

	// due slots still ahead of the one being served
	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			above[j] = (IW'(j) > idx_s1);
		end
	end
	assign more = |(used_q & due_q & above);

	assign sts.s0_end   = s0_end;
	assign sts.s0_free  = !used_q[idx0];
	assign sts.s1_vld   = vld_s1;
	assign sts.s1_hit   = used_q[idx_s1] && due_q[idx_s1];
	assign sts.s1_last  = !more || (res_q == RW'(potb_pkg::RESULT_CAP - 1));
	assign sts.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			period_q <= period;
			single_q <= one_shot;
		end
		if (create_act) begin
			per_mem[idx0] <= {single_q, period_q};
		end
		if (cnt_we) begin
			cnt_mem[cnt_addr] <= cnt_wdata;
		end
		if (step0) begin
			per_s1 <= per_mem[idx0];
			cnt_s1 <= cnt_mem[idx0];
			idx_s1 <= idx0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
			res_q  <= '0;
			used_q <= '0;
			due_q  <= '0;
			live_q <= '0;
		end else begin
			if (cmd.start) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
				res_q  <= '0;
			end else begin
				if (step0) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmd.adv) begin
					vld_s1 <= !s0_end;
				end
				if (serve) begin
					res_q <= res_q + 1'b1;
				end
			end
			if (create_act) begin
				used_q[idx0] <= 1'b1;
				due_q[idx0]  <= 1'b0;
				live_q       <= live_q + 1'b1;
			end
			if (tick_act && fire) begin
				due_q[idx_s1] <= 1'b1;
			end
			if (serve) begin
				due_q[idx_s1] <= 1'b0;
				if (per_s1[PW]) begin
					used_q[idx_s1] <= 1'b0;
					live_q         <= live_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != potb_pkg::EM_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.emit)
			potb_pkg::EM_CREATE: begin
				kind_q     <= potb_pkg::KIND_CREATE;
				slot_q     <= potb_pkg::SLOT_W'(idx0);
				was_q      <= 1'b0;
				full_q     <= 1'b0;
				live_out_q <= potb_pkg::LIVE_W'(live_q + 1'b1);
				last_q     <= 1'b1;
			end
			potb_pkg::EM_FULL: begin
				kind_q     <= potb_pkg::KIND_CREATE;
				slot_q     <= '0;
				was_q      <= 1'b0;
				full_q     <= 1'b1;
				live_out_q <= potb_pkg::LIVE_W'(live_q);
				last_q     <= 1'b1;
			end
			potb_pkg::EM_DUE: begin
				kind_q     <= potb_pkg::KIND_DUE;
				slot_q     <= potb_pkg::SLOT_W'(idx_s1);
				was_q      <= per_s1[PW];
				full_q     <= 1'b0;
				live_out_q <= potb_pkg::LIVE_W'(live_q - LW'(per_s1[PW]));
				last_q     <= sts.s1_last;
			end
			potb_pkg::EM_EMPTY: begin
				kind_q     <= potb_pkg::KIND_NONE;
				slot_q     <= '0;
				was_q      <= 1'b0;
				full_q     <= 1'b0;
				live_out_q <= potb_pkg::LIVE_W'(live_q);
				last_q     <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign slot         = slot_q;
	assign was_one_shot = was_q;
	assign full_error   = full_q;
	assign live_count   = live_out_q;
	assign last         = last_q;

`include "periodic_oneshot_timer_bank_assert.svh"

	`POTB_ASSERT_NOW(a_live_matches_used, 1'b1, $countones(used_q) == int'(live_q))
	`POTB_ASSERT_NOW(a_due_only_used, 1'b1, (due_q & ~used_q) == '0)
	`POTB_ASSERT_NOW(a_emit_needs_room, cmd.emit != potb_pkg::EM_NONE, out_free)
	`POTB_ASSERT_NEXT(a_emit_shows, cmd.emit != potb_pkg::EM_NONE, out_valid_q)
	`POTB_ASSERT_NOW(a_serve_hits_due, serve, vld_s1 && used_q[idx_s1] && due_q[idx_s1])

endmodule

// ----- sv/periodic_oneshot_timer_bank.sv -----
// channel | handshake            | fields
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_stall  | operation, period, one_shot
// out     | out_valid / out_stall| kind, slot, was_one_shot, full_error, live_count, last
//
// a tick walks the slot table one slot per cycle
// a create walks until the first free slot, or reports full at the end of the table
// a poll walks the table, one result per due slot
// the walk speed is set by the single read port of the period and count memories
// reset clears the used and due marks; no clearing pass, the bank is ready at once
// a stall on out holds the walk at the pending due slot; in stalls while an item is at work
module periodic_oneshot_timer_bank #(
	parameter int SLOTS      = potb_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = potb_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [potb_pkg::OP_W-1:0]       operation,
	input  logic [potb_pkg::PERIOD_W-1:0]   period,
	input  logic                            one_shot,
	// result items
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [potb_pkg::KIND_W-1:0]     kind,
	output logic [potb_pkg::SLOT_W-1:0]     slot,
	output logic                            was_one_shot,
	output logic                            full_error,
	output logic [potb_pkg::LIVE_W-1:0]     live_count,
	output logic                            last
);

	// command and status between sequencer and slot table
	potb_pkg::cmd_t cmd;
	potb_pkg::sts_t sts;

	// sequencer: takes one item, steps the walk, decides which result goes out
	potb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot table, counters, walk pipeline and the output register
	potb_dpath #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.period       (period),
		.one_shot     (one_shot),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.slot         (slot),
		.was_one_shot (was_one_shot),
		.full_error   (full_error),
		.live_count   (live_count),
		.last         (last)
	);

endmodule

// ----- dv/timer_bank_checker.sv -----
module timer_bank_checker
	import potb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [PERIOD_W-1:0] period,
	input  logic                one_shot,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [KIND_W-1:0]   kind,
	input  logic [SLOT_W-1:0]   slot,
	input  logic                was_one_shot,
	input  logic                full_error,
	input  logic [LIVE_W-1:0]   live_count,
	input  logic                last,
	output int                  mismatches,
	output int                  results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = SLOTS_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic              was_one_shot;
		logic              full_error;
		logic [LIVE_W-1:0] live_count;
		logic              last;
	} timer_result_t;

	// shadow copy of the slot table
	bit                        slot_taken    [SLOTS];
	bit                        slot_fired    [SLOTS];
	bit                        slot_single   [SLOTS];
	logic [PERIOD_W-1:0]       slot_interval [SLOTS];
	logic [COUNT_BITS_DEF-1:0] slot_elapsed  [SLOTS];
	int                        live_slots;
	timer_result_t             awaited_results [$];

	function automatic void queue_result(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
		logic single, logic full, logic fin);
		timer_result_t r;
		r.kind         = k;
		r.slot         = s;
		r.was_one_shot = single;
		r.full_error   = full;
		r.live_count   = live_slots[LIVE_W-1:0];
		r.last         = fin;
		awaited_results.push_back(r);
	endfunction

	function automatic void advance_timers();
		logic [COUNT_BITS_DEF-1:0] c;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_taken[i] && !slot_fired[i]) begin
				c = slot_elapsed[i];
				if (c != COUNT_MAX)
					c++;
				// a saturated count fires even if the period is not reached
				if (c >= slot_interval[i] || c == COUNT_MAX) begin
					slot_elapsed[i] = '0;
					slot_fired[i]   = 1'b1;
				end else begin
					slot_elapsed[i] = c;
				end
			end
		end
	endfunction

	function automatic void alloc_timer(logic [PERIOD_W-1:0] per, logic single);
		int free_idx;
		free_idx = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (!slot_taken[i]) begin
				free_idx = i;
				break;
			end
		end
		if (free_idx < 0) begin
			queue_result(KIND_CREATE, '0, 1'b0, 1'b1, 1'b1);
		end else begin
			slot_taken[free_idx]    = 1'b1;
			slot_fired[free_idx]    = 1'b0;
			slot_interval[free_idx] = per;
			slot_elapsed[free_idx]  = '0;
			slot_single[free_idx]   = single;
			live_slots++;
			queue_result(KIND_CREATE, free_idx[SLOT_W-1:0], 1'b0, 1'b0, 1'b1);
		end
	endfunction

	function automatic void serve_due();
		int to_serve;
		int served;
		bit single;
		to_serve = 0;
		served   = 0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_taken[i] && slot_fired[i])
				to_serve++;
		if (to_serve > RESULT_CAP)
			to_serve = RESULT_CAP;
		for (int i = 0; i < SLOTS && served < to_serve; i++) begin
			if (slot_taken[i] && slot_fired[i]) begin
				single        = slot_single[i];
				slot_fired[i] = 1'b0;
				if (single) begin
					slot_taken[i] = 1'b0;
					live_slots--;
				end
				served++;
				queue_result(KIND_DUE, i[SLOT_W-1:0], single, 1'b0, served == to_serve);
			end
		end
		if (to_serve == 0)
			queue_result(KIND_NONE, '0, 1'b0, 1'b0, 1'b1);
	endfunction

	function automatic bit field_differs(string name, int unsigned want, int unsigned got);
		if (want != got)
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return want != got;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		bit bad;
		if (!arst_n) begin
			foreach (slot_taken[i]) begin
				slot_taken[i] = 1'b0;
				slot_fired[i] = 1'b0;
			end
			live_slots = 0;
			mismatches = 0;
			awaited_results.delete();
		end else begin
			// results first: whatever leaves now was caused by an earlier item
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result kind %0d slot %0d", $time, kind, slot);
				end else begin
					want = awaited_results.pop_front();
					bad  = field_differs("kind", 32'(want.kind), 32'(kind));
					bad |= field_differs("slot", 32'(want.slot), 32'(slot));
					bad |= field_differs("was_one_shot", 32'(want.was_one_shot),
						32'(was_one_shot));
					bad |= field_differs("full_error", 32'(want.full_error),
						32'(full_error));
					bad |= field_differs("live_count", 32'(want.live_count),
						32'(live_count));
					bad |= field_differs("last", 32'(want.last), 32'(last));
					if (bad)
						mismatches++;
				end
			end
			if (in_valid && !in_stall) begin
				case (operation)
					OP_TICK:   advance_timers();
					OP_CREATE: alloc_timer(period, one_shot);
					OP_POLL:   serve_due();
					default:   ;
				endcase
			end
		end
		results_owed = awaited_results.size();
	end

endmodule

// ----- dv/testbench.sv -----
module testbench;
	import potb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// unassigned operation code, the block drops such items
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS   = 300;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 4 * SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 4000;

	// idle percentages per phase: none, sender idle, receiver stalls, both light
	localparam int SEND_IDLE [4] = '{0, 71, 0, 7};
	localparam int RECV_STALL[4] = '{0, 0, 71, 7};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     operation;
	logic [PERIOD_W-1:0] period;
	logic                one_shot;
	logic                out_valid;
	logic                out_stall;
	logic [KIND_W-1:0]   kind;
	logic [SLOT_W-1:0]   slot;
	logic                was_one_shot;
	logic                full_error;
	logic [LIVE_W-1:0]   live_count;
	logic                last;

	int mismatches;
	int results_owed;
	int send_idle_pct;
	int recv_stall_pct;
	bit long_hold;

	periodic_oneshot_timer_bank DUT (.*);

	// watches both channels, predicts every result and counts mismatches
	timer_bank_checker checker_inst (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				// hold results back so the block backs up into its input
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// give up if neither channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("periodic_oneshot_timer_bank: mismatch");
		$finish;
	end

	// present one item at a falling edge, hold it until taken, then maybe go idle
	task automatic offer_item(logic [OP_W-1:0] op, logic [PERIOD_W-1:0] per, logic single);
		operation <= op;
		period    <= per;
		one_shot  <= single;
		in_valid  <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
	endtask

	initial begin
		int sent;
		int pick;
		logic [OP_W-1:0]     op;
		logic [PERIOD_W-1:0] per;
		logic                single;

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		operation      = OP_TICK;
		period         = '0;
		one_shot       = 1'b0;
		long_hold      = 1'b0;
		send_idle_pct  = SEND_IDLE[0];
		recv_stall_pct = RECV_STALL[0];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table: poll reports nothing due, unused code is dropped
		offer_item(OP_POLL, '0, 1'b0);
		offer_item(OP_UNUSED, '1, 1'b1);
		// zero period fires on the first tick, period one as well
		offer_item(OP_CREATE, '0, 1'b0);
		offer_item(OP_CREATE, 16'd1, 1'b1);
		offer_item(OP_TICK, '0, 1'b0);
		offer_item(OP_POLL, '0, 1'b0);
		// fill every slot, then one more create must report full
		repeat (SLOTS_DEF - 1) offer_item(OP_CREATE, '0, 1'b1);
		offer_item(OP_CREATE, 16'd5, 1'b1);
		// all sixteen due at once: the largest poll, one-shots freed
		offer_item(OP_TICK, '0, 1'b0);
		offer_item(OP_POLL, '0, 1'b0);
		// widest period, never fires within the run
		offer_item(OP_CREATE, '1, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct  = SEND_IDLE[phase];
			recv_stall_pct = RECV_STALL[phase];
			// long receiver hold while the sender keeps going at full rate
			if (phase == 0)
				long_hold = 1'b1;
			sent = 0;
			while (sent < RANDOM_ITEMS / 4) begin
				pick   = $urandom_range(0, 99);
				per    = PERIOD_W'($urandom_range(0, 65535));
				single = 1'($urandom_range(0, 1));
				if (pick < 5) begin
					op = OP_UNUSED;
				end else if (pick < 45) begin
					op = OP_TICK;
				end else if (pick < 75) begin
					op = OP_CREATE;
					// mostly short one-shots so slots keep turning over
					pick = $urandom_range(0, 19);
					if (pick >= 1 && pick < 4)
						per = PERIOD_W'($urandom_range(7, 40));
					else if (pick >= 4)
						per = PERIOD_W'($urandom_range(0, 6));
					single = ($urandom_range(0, 9) != 0);
				end else begin
					op = OP_POLL;
				end
				offer_item(op, per, single);
				if (op != OP_UNUSED)
					sent++;
			end
			// sender pause: let the block drain completely
			if (phase == 1) begin
				in_valid <= 1'b0;
				wait (results_owed == 0);
				@(negedge clk);
			end
		end
		in_valid <= 1'b0;

		wait (results_owed == 0);
		// ticks and dropped items leave nothing to wait for, give them time
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("periodic_oneshot_timer_bank: match");
		else
			$display("periodic_oneshot_timer_bank: mismatch");
		$finish;
	end

endmodule
